>>> sv/jesc_pkg.sv
// Shared types, constants and the exp(-|z|) table for the Julia escape-time block.
// Used by jesc_ctrl, jesc_dp, julia_escape_smooth_color, jesc_checker and the testbench; depends on nothing else.
`default_nettype none
package jesc_pkg;

	// Number format and table size.
	localparam int FRAC_BITS       = 24;
	localparam int EXP_TABLE_DEPTH = 768;

	// Port widths fixed by the interface.
	localparam int CFG_W   = 28;
	localparam int START_W = 27;
	localparam int SUM_W   = 29;
	localparam int ITER_W  = 12;
	localparam int IDX_W   = 3;
	localparam int TERM_W  = 17;

	// Internal widths: z stays below 2^29 in magnitude, so 31 bits hold it with margin.
	localparam int ZW = 31;
	localparam int PW = 2 * ZW;
	localparam int MW = PW - FRAC_BITS;

	// Table index width and square root geometry (k = isqrt(m >> (F - 12))).
	localparam int KW     = $clog2(EXP_TABLE_DEPTH);
	localparam int RAD_W  = 2 * KW;
	localparam int REM_W  = KW + 2;
	localparam int CNT_W  = $clog2(KW + 1);
	localparam int RAD_SH = FRAC_BITS - 12;
	localparam logic [MW-1:0] RAD_LIMIT = MW'(EXP_TABLE_DEPTH * EXP_TABLE_DEPTH);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_C_REAL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_C_IMAG   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd3;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0]  RADIUS_RESET   = 28'd67108864;
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 12'd1000;

	// Operand pairs of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_SEL_RR,
		MUL_SEL_II,
		MUL_SEL_RI
	} mul_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_MAG,
		ST_SQ_LOAD,
		ST_SQRT,
		ST_ROM,
		ST_ACC,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     mag_en;
		logic     sq_load;
		logic     sq_step;
		logic     rom_en;
		logic     acc_en;
		logic     advance;
		logic     out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic keep_going;
	} dp_status_t;

	typedef logic [TERM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

	// Builds round(65536 * exp(-k/64)) with 64 fraction bits, evaluated at elaboration.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t     rom;
		logic [63:0]  q;
		logic [63:0]  term;
		logic [63:0]  v;
		logic [127:0] prod;
		q    = 64'hFC00000000000000 + (64'd1 << 51);
		term = 64'd1 << 51;
		for (int n = 3; n <= 20; n++) begin
			term = term / 64'(64 * n);
			if ((n % 2) == 1) begin
				q = q - term;
			end else begin
				q = q + term;
			end
		end
		rom[0] = TERM_W'(65536);
		v = q;
		for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
			rom[k] = TERM_W'((v + (64'd1 << 47)) >> 48);
			prod   = 128'(v) * 128'(q);
			v      = prod[127:64];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage
`default_nettype wire

>>> sv/jesc_ctrl.sv
// Controller state machine for the Julia escape-time block.
// Depends on jesc_pkg; drives jesc_dp through dp_cmd_t and reads dp_status_t.
`default_nettype none
module jesc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output jesc_pkg::dp_cmd_t        cmd,
	input  wire jesc_pkg::dp_status_t status
);

	jesc_pkg::state_t             state_q;
	jesc_pkg::state_t             state_next;
	logic [jesc_pkg::CNT_W-1:0]   cnt_q;
	logic                         out_valid_q;
	logic                         slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State, square root step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jesc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == jesc_pkg::ST_SQ_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == jesc_pkg::ST_SQRT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next  = state_q;
		cmd         = '0;
		cmd.mul_sel = jesc_pkg::MUL_SEL_RR;
		in_ready    = 1'b0;
		case (state_q)
			jesc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = jesc_pkg::ST_MUL_RR;
				end
			end
			jesc_pkg::ST_MUL_RR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jesc_pkg::MUL_SEL_RR;
				state_next  = jesc_pkg::ST_MUL_II;
			end
			jesc_pkg::ST_MUL_II: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jesc_pkg::MUL_SEL_II;
				state_next  = jesc_pkg::ST_MUL_RI;
			end
			jesc_pkg::ST_MUL_RI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jesc_pkg::MUL_SEL_RI;
				state_next  = jesc_pkg::ST_MAG;
			end
			jesc_pkg::ST_MAG: begin
				cmd.mag_en = 1'b1;
				state_next = jesc_pkg::ST_SQ_LOAD;
			end
			jesc_pkg::ST_SQ_LOAD: begin
				cmd.sq_load = 1'b1;
				state_next  = jesc_pkg::ST_SQRT;
			end
			jesc_pkg::ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (cnt_q == jesc_pkg::CNT_W'(jesc_pkg::KW - 1)) begin
					state_next = jesc_pkg::ST_ROM;
				end
			end
			jesc_pkg::ST_ROM: begin
				cmd.rom_en = 1'b1;
				state_next = jesc_pkg::ST_ACC;
			end
			jesc_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (status.keep_going) begin
					cmd.advance = 1'b1;
					state_next  = jesc_pkg::ST_MUL_RR;
				end else begin
					state_next = jesc_pkg::ST_DONE;
				end
			end
			jesc_pkg::ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_next   = jesc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = jesc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/jesc_dp.sv
// Datapath of the Julia escape-time block: configuration, z iteration, square root,
// exp table and result registers. Depends on jesc_pkg; commanded by jesc_ctrl.
`default_nettype none
module jesc_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [jesc_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [jesc_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic signed [jesc_pkg::START_W-1:0] start_real,
	input  wire logic signed [jesc_pkg::START_W-1:0] start_imag,
	input  wire jesc_pkg::dp_cmd_t               cmd,
	output jesc_pkg::dp_status_t                 status,
	output logic [jesc_pkg::SUM_W-1:0]           color_sum,
	output logic [jesc_pkg::ITER_W-1:0]          iteration_count,
	output logic                                 escaped
);

	localparam int ZW = jesc_pkg::ZW;
	localparam int PW = jesc_pkg::PW;
	localparam int MW = jesc_pkg::MW;
	localparam int KW = jesc_pkg::KW;
	localparam int F  = jesc_pkg::FRAC_BITS;

	logic signed [jesc_pkg::CFG_W-1:0] c_real_q;
	logic signed [jesc_pkg::CFG_W-1:0] c_imag_q;
	logic [jesc_pkg::CFG_W-1:0]        radius_q;
	logic [jesc_pkg::ITER_W-1:0]       max_iter_q;

	logic signed [ZW-1:0] zr_q, zi_q, nr_q, ni_q;
	logic signed [ZW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q;
	logic signed [PW-1:0] diff, dbl;
	logic [PW-1:0]        sum_sq;
	logic [MW-1:0]        m_q;
	logic [MW-1:0]        rad_full;
	logic [jesc_pkg::RAD_W-1:0] rad_q;
	logic [jesc_pkg::REM_W-1:0] rem_q, rem_try, trial;
	logic [KW-1:0]        root_q;
	logic                 big_q;
	logic [jesc_pkg::TERM_W-1:0] rom_q;
	logic [jesc_pkg::SUM_W-1:0]  sum_q;
	logic [jesc_pkg::ITER_W-1:0] it_q;
	logic                 below_radius;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q   <= '0;
			c_imag_q   <= '0;
			radius_q   <= jesc_pkg::RADIUS_RESET;
			max_iter_q <= jesc_pkg::MAX_ITER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				jesc_pkg::REG_C_REAL:   c_real_q   <= cfg_data;
				jesc_pkg::REG_C_IMAG:   c_imag_q   <= cfg_data;
				jesc_pkg::REG_RADIUS:   radius_q   <= cfg_data;
				jesc_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[jesc_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.mul_sel)
			jesc_pkg::MUL_SEL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			jesc_pkg::MUL_SEL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			jesc_pkg::MUL_SEL_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end
	assign prod = PW'(mul_a) * PW'(mul_b);

	// Magnitude and next point; arithmetic right shift is the floor.
	assign sum_sq = PW'(p_rr_q + p_ii_q);
	assign diff   = p_rr_q - p_ii_q;
	assign dbl    = p_ri_q <<< 1;

	// Square root step: one result bit per cycle.
	assign rad_full = m_q >> jesc_pkg::RAD_SH;
	assign rem_try  = {rem_q[jesc_pkg::REM_W-3:0], rad_q[jesc_pkg::RAD_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};

	assign below_radius      = m_q < MW'(radius_q);
	assign status.keep_going = below_radius && (it_q < max_iter_q);

	// Iteration registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q  <= ZW'(start_real);
			zi_q  <= ZW'(start_imag);
			sum_q <= '0;
			it_q  <= '0;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				jesc_pkg::MUL_SEL_RR: p_rr_q <= prod;
				jesc_pkg::MUL_SEL_II: p_ii_q <= prod;
				jesc_pkg::MUL_SEL_RI: p_ri_q <= prod;
				default: ;
			endcase
		end
		if (cmd.mag_en) begin
			m_q  <= sum_sq[PW-1:F];
			nr_q <= ZW'(diff >>> F) + ZW'(c_real_q);
			ni_q <= ZW'(dbl >>> F) + ZW'(c_imag_q);
		end
		if (cmd.sq_load) begin
			rad_q  <= rad_full[jesc_pkg::RAD_W-1:0];
			big_q  <= rad_full >= jesc_pkg::RAD_LIMIT;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sq_step) begin
			rad_q <= rad_q << 2;
			if (rem_try >= trial) begin
				rem_q  <= rem_try - trial;
				root_q <= {root_q[KW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_try;
				root_q <= {root_q[KW-2:0], 1'b0};
			end
		end
		// Table read, registered like a ROM port.
		if (cmd.rom_en) begin
			rom_q <= jesc_pkg::EXP_ROM[root_q];
		end
		if (cmd.acc_en) begin
			sum_q <= sum_q + (big_q ? '0 : jesc_pkg::SUM_W'(rom_q));
		end
		if (cmd.advance) begin
			zr_q <= nr_q;
			zi_q <= ni_q;
			it_q <= it_q + 1'b1;
		end
		// Result register.
		if (cmd.out_load) begin
			color_sum       <= sum_q;
			iteration_count <= it_q;
			escaped         <= !below_radius;
		end
	end

endmodule
`default_nettype wire

>>> sv/julia_escape_smooth_color.sv
// Top level of the Julia escape-time block with smooth color sum.
// Depends on jesc_pkg, jesc_ctrl and jesc_dp.
//
// Usage: write c_real, c_imag, escape_radius_squared and max_iterations through
// cfg_we/cfg_index/cfg_data while the block is idle. Each start point arrives as
// one item on in_valid/in_ready; one result item (color_sum, iteration_count,
// escaped) leaves on out_valid/out_ready.
// Timing: one point is worked on at a time. Each iteration runs three passes
// through the shared multiplier, one magnitude step, a square root load, KW bit
// steps of the square root unit, a table read and the accumulate. A new item
// can be accepted in the same cycle that out_valid rises; the iterative square
// root sets the iteration time.
// The result sits in an output register, so in_ready rises again as soon as a
// result is loaded, even if the receiver has not taken it. If the receiver stalls
// and a new result is done, the block waits with that result until the slot frees.
// Reset restores the register defaults (c = 0, radius squared 4.0, limit 1000),
// empties the output register and returns the controller to idle.
`default_nettype none
module julia_escape_smooth_color (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [jesc_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [jesc_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [jesc_pkg::START_W-1:0]  start_real,
	input  wire logic signed [jesc_pkg::START_W-1:0]  start_imag,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [jesc_pkg::SUM_W-1:0]                color_sum,
	output logic [jesc_pkg::ITER_W-1:0]               iteration_count,
	output logic                                      escaped
);

	jesc_pkg::dp_cmd_t    cmd;
	jesc_pkg::dp_status_t status;

	// Sequencer.
	jesc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Arithmetic and storage.
	jesc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start_real      (start_real),
		.start_imag      (start_imag),
		.cmd             (cmd),
		.status          (status),
		.color_sum       (color_sum),
		.iteration_count (iteration_count),
		.escaped         (escaped)
	);

endmodule
`default_nettype wire

>>> sv/jesc_checker.sv
// Port-level checks for julia_escape_smooth_color, bound to the top level.
// Depends on jesc_pkg for port widths.
`default_nettype none
module jesc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [jesc_pkg::SUM_W-1:0]         color_sum,
	input wire logic [jesc_pkg::ITER_W-1:0]        iteration_count
);

	// A pending result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped before it was taken");

	// A pending result's color_sum and iteration_count do not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(color_sum) && $stable(iteration_count))
		else $error("result item changed while stalled");

	// Only one point is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

	// No result appears in the cycle right after an item is accepted.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result item appeared too early");

endmodule

bind julia_escape_smooth_color jesc_checker u_jesc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.color_sum       (color_sum),
	.iteration_count (iteration_count)
);
`default_nettype wire

>>> tb/julia_escape_smooth_color_tb.sv
// Self-checking testbench for julia_escape_smooth_color: directed and random start points under
// several register settings, checked against a fixed-point predictor held in a scoreboard class.
// Depends on jesc_pkg and the RTL of the block.
`default_nettype none
module julia_escape_smooth_color_tb;

	// Register indexes that select no register; writes to them must be ignored.
	localparam logic [jesc_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [jesc_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int ONE_Q   = 1 << jesc_pkg::FRAC_BITS;
	localparam int DRAIN_PAD = 60;

	typedef struct {
		logic [jesc_pkg::SUM_W-1:0]  sum;
		logic [jesc_pkg::ITER_W-1:0] count;
		logic                        esc;
	} escape_result_t;

	// Scoreboard: mirrors the registers, predicts each point's result and checks outputs.
	class escape_scoreboard;
		logic [jesc_pkg::CFG_W-1:0]  c_re;
		logic [jesc_pkg::CFG_W-1:0]  c_im;
		logic [jesc_pkg::CFG_W-1:0]  radius_sq;
		logic [jesc_pkg::ITER_W-1:0] iter_limit;
		int unsigned       exp_lut [jesc_pkg::EXP_TABLE_DEPTH];
		escape_result_t    awaited [$];
		int                errors;
		int                points;
		int                results;
		int                escapes;

		function new();
			logic [63:0]  q;
			logic [63:0]  t;
			logic [63:0]  v;
			logic [127:0] p;
			c_re       = '0;
			c_im       = '0;
			radius_sq  = jesc_pkg::RADIUS_RESET;
			iter_limit = jesc_pkg::MAX_ITER_RESET;
			errors     = 0;
			points     = 0;
			results    = 0;
			escapes    = 0;
			// Series for exp(-1/64) with 64 fraction bits, then powers of it.
			q = 64'hFC00000000000000 + (64'd1 << 51);
			t = 64'd1 << 51;
			for (int n = 3; n <= 20; n++) begin
				t = t / (64 * n);
				q = (n % 2 == 1) ? q - t : q + t;
			end
			exp_lut[0] = 65536;
			v = q;
			for (int k = 1; k < jesc_pkg::EXP_TABLE_DEPTH; k++) begin
				exp_lut[k] = int'((v + (64'd1 << 47)) >> 48);
				p = {64'd0, v} * {64'd0, q};
				v = p[127:64];
			end
		endfunction

		function void write_reg(logic [jesc_pkg::IDX_W-1:0] idx,
		                        logic [jesc_pkg::CFG_W-1:0] data);
			case (idx)
				jesc_pkg::REG_C_REAL:   c_re = data;
				jesc_pkg::REG_C_IMAG:   c_im = data;
				jesc_pkg::REG_RADIUS:   radius_sq = data;
				jesc_pkg::REG_MAX_ITER: iter_limit = data[jesc_pkg::ITER_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b   = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x   = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// exp(-|z|) table term for a squared magnitude m in Q.F.
		function longint unsigned decay_term(longint unsigned m);
			longint unsigned k;
			k = root_floor(m << jesc_pkg::FRAC_BITS) >> (jesc_pkg::FRAC_BITS - 6);
			return (k < jesc_pkg::EXP_TABLE_DEPTH) ? longint'(exp_lut[k]) : 0;
		endfunction

		function longint unsigned mag_sq(longint zr, longint zi);
			return longint'(zr * zr + zi * zi) >> jesc_pkg::FRAC_BITS;
		endfunction

		// Run the escape iteration for an accepted point and queue the result.
		function void note_point(logic signed [jesc_pkg::START_W-1:0] sr,
		                         logic signed [jesc_pkg::START_W-1:0] si);
			longint          zr;
			longint          zi;
			longint          cr;
			longint          ci;
			longint          nr;
			longint          ni;
			longint unsigned m;
			longint unsigned total;
			int              n;
			escape_result_t  e;
			zr = sr;
			zi = si;
			cr = $signed(c_re);
			ci = $signed(c_im);
			m  = mag_sq(zr, zi);
			total = decay_term(m);
			n = 0;
			while (m < longint'(radius_sq) && n < int'(iter_limit)) begin
				nr = ((zr * zr - zi * zi) >>> jesc_pkg::FRAC_BITS) + cr;
				ni = ((2 * zr * zi) >>> jesc_pkg::FRAC_BITS) + ci;
				zr = nr;
				zi = ni;
				m  = mag_sq(zr, zi);
				total += decay_term(m);
				n++;
			end
			e.sum   = total[jesc_pkg::SUM_W-1:0];
			e.count = n[jesc_pkg::ITER_W-1:0];
			e.esc   = (m >= longint'(radius_sq));
			awaited.push_back(e);
			points++;
		endfunction

		function void check_result(logic [jesc_pkg::SUM_W-1:0] sum,
		                           logic [jesc_pkg::ITER_W-1:0] count, logic esc);
			escape_result_t e;
			results++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Result item with no point pending: sum %0d count %0d esc %0b",
						sum, count, esc);
				return;
			end
			e = awaited.pop_front();
			if (e.esc) escapes++;
			if (sum !== e.sum || count !== e.count || esc !== e.esc) begin
				errors++;
				if (errors <= 10)
					$display({"Mismatch on result %0d: expected sum %0d count %0d esc %0b,",
						" got sum %0d count %0d esc %0b"},
						results, e.sum, e.count, e.esc, sum, count, esc);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [jesc_pkg::IDX_W-1:0]          cfg_index;
	logic [jesc_pkg::CFG_W-1:0]          cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic signed [jesc_pkg::START_W-1:0] start_real;
	logic signed [jesc_pkg::START_W-1:0] start_imag;
	logic                                out_valid;
	logic                                out_ready;
	logic [jesc_pkg::SUM_W-1:0]          color_sum;
	logic [jesc_pkg::ITER_W-1:0]         iteration_count;
	logic                                escaped;

	escape_scoreboard sb;
	int send_idle;
	int recv_idle;
	int settings;

	julia_escape_smooth_color u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_real(start_real), .start_imag(start_imag),
		.out_valid(out_valid), .out_ready(out_ready),
		.color_sum(color_sum), .iteration_count(iteration_count), .escaped(escaped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver stalls at the rate of the current idling mode.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Monitor: sees values from before the edge, so it never races the drivers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_point(start_real, start_imag);
			if (out_valid && out_ready) sb.check_result(color_sum, iteration_count, escaped);
		end
	end

	// Offer one point; returns at the edge where it is accepted.
	task automatic send_point(input logic [jesc_pkg::START_W-1:0] sr,
	                          input logic [jesc_pkg::START_W-1:0] si);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid   <= 1'b1;
		start_real <= sr;
		start_imag <= si;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Hold off new points until every result is back, then let the block settle.
	// The first edge lets the monitor note a point accepted at the current edge.
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < 400_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// One register write; the port is idle again before the task returns.
	task automatic write_reg(input logic [jesc_pkg::IDX_W-1:0] idx,
	                         input logic [jesc_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [jesc_pkg::CFG_W-1:0] cr,
	                         input logic [jesc_pkg::CFG_W-1:0] ci,
	                         input logic [jesc_pkg::CFG_W-1:0] rad,
	                         input logic [jesc_pkg::ITER_W-1:0] lim);
		drain();
		write_reg(jesc_pkg::REG_C_REAL, cr);
		write_reg(jesc_pkg::REG_C_IMAG, ci);
		write_reg(jesc_pkg::REG_RADIUS, rad);
		write_reg(jesc_pkg::REG_MAX_ITER, jesc_pkg::CFG_W'(lim));
		settings++;
	endtask

	// Random point: mostly inside the interesting +-2 box, sometimes any bit pattern.
	function automatic logic [jesc_pkg::START_W-1:0] rand_coord();
		if ($urandom_range(3) == 0) return jesc_pkg::START_W'($urandom);
		return jesc_pkg::START_W'(int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q);
	endfunction

	task automatic random_points(input int count);
		repeat (count) send_point(rand_coord(), rand_coord());
	endtask

	initial begin
		bit failed;
		sb         = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		start_real = '0;
		start_imag = '0;
		out_ready  = 1'b0;
		send_idle  = 37;
		recv_idle  = 51;
		settings   = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset settings: a bounded point, the start extremes and immediate escapes.
		send_point('0, '0);
		send_point(27'h3FFFFFF, 27'h3FFFFFF);
		send_point(27'h4000000, 27'h4000000);
		send_point(27'h3FFFFFF, 27'h4000000);
		send_point(27'(3 * ONE_Q), '0);
		send_point('0, 27'(-3 * ONE_Q));
		send_point(27'(ONE_Q / 2), 27'(ONE_Q / 2));

		// Large c and radius: a first step can land past the end of the table.
		configure(28'h7FFFFFF, 28'h8000000, 28'hFFFFFFF, 12'd4095);
		write_reg(REG_SPARE_LO, 28'h5555555);
		write_reg(REG_SPARE_HI, 28'hAAAAAAA);
		send_point('0, '0);
		send_point(27'(ONE_Q * 39 / 10), '0);
		send_point(27'h4000000, 27'h3FFFFFF);

		// Zero iteration limit: only the start point's term counts.
		configure(28'(-ONE_Q), 28'(ONE_Q / 4), 28'(9 * ONE_Q), 12'd0);
		send_point('0, '0);
		send_point(27'(3 * ONE_Q), 27'(2 * ONE_Q));
		send_point(27'h4000000, '0);

		// Zero radius: always escaped, no iteration.
		configure('0, '0, '0, 12'd50);
		send_point(27'(ONE_Q), 27'(-ONE_Q));
		send_point('0, '0);

		// One step limit where the first step also escapes: radius test wins.
		configure(28'(2 * ONE_Q), '0, 28'(4 * ONE_Q), 12'd1);
		send_point('0, '0);
		send_point(27'(ONE_Q / 8), '0);

		// Longest limit on a point that never leaves.
		configure('0, '0, 28'(4 * ONE_Q), 12'd4095);
		send_point(27'(ONE_Q / 2), '0);

		// Random settings and points, idling mode changing as the run goes on.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 3) begin
				send_idle = 51;
				recv_idle = 37;
			end else if (ph == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(4) == 0)
				configure(28'($urandom), 28'($urandom), 28'($urandom),
					12'($urandom_range(0, 8)));
			else
				configure(28'(int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q),
					28'(int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q),
					28'($urandom_range(0, 9 * ONE_Q)), 12'($urandom_range(0, 48)));
			random_points(8);
			if (ph == 4) drain();
			random_points(7);
		end

		drain();
		$display("Checked %0d results for %0d start points (%0d escaped) over %0d register settings.",
			sb.results, sb.points, sb.escapes, settings);
		failed = (sb.errors != 0) || (sb.pending() != 0);
		if (sb.pending() != 0) $display("%0d results never arrived.", sb.pending());
		if (!failed) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
sv/jesc_pkg.sv
sv/jesc_ctrl.sv
sv/jesc_dp.sv
sv/julia_escape_smooth_color.sv
sv/jesc_checker.sv
tb/julia_escape_smooth_color_tb.sv
